// File: src/udprd_pkg.sv
// Shared types and constants for the UDP receive port demultiplexer.
// No dependencies; imported by every module of the block.
`default_nettype none

package udprd_pkg;

    localparam int MAX_SLOTS      = 8;
    localparam int SLOT_COUNT_DEF = 8;
    localparam int SLOT_W         = 3;
    localparam int PORT_W         = 16;
    localparam int CFG_INDEX_W    = 4;
    localparam int CFG_DATA_W     = 17;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [15:0] HEADER_BYTES = 16'd8;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    localparam logic KIND_PAYLOAD    = 1'b0;
    localparam logic KIND_DESCRIPTOR = 1'b1;

    typedef struct packed {
        logic        found;
        logic [SLOT_W-1:0] slot;
    } match_t;

    typedef struct packed {
        logic               result_kind;
        logic [7:0]         payload_byte;
        logic [SLOT_W-1:0]  slot_index;
        logic               delivered;
        logic [31:0]        peer_address;
        logic [PORT_W-1:0]  peer_port;
        logic [15:0]        payload_length;
        logic               final_result;
    } result_t;

endpackage

`default_nettype wire

// File: src/udprd_slot_match.sv
// Slot registers and lowest-slot destination port match.
// Depends on udprd_pkg.
`default_nettype none

module udprd_slot_match #(
    parameter int SLOT_COUNT = udprd_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [udprd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [udprd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [udprd_pkg::PORT_W-1:0]       dest_port,
    output udprd_pkg::match_t                       match
);
    import udprd_pkg::*;

    logic [CFG_DATA_W-1:0] slot_reg [SLOT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (cfg_write && cfg_index == CFG_INDEX_W'(i))
                begin
                    slot_reg[i] <= cfg_data;
                end
            end
        end
    end

    // scan from the top so the lowest matching slot wins
    always_comb
    begin
        match.found = 1'b0;
        match.slot  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (slot_reg[i][PORT_W] && slot_reg[i][PORT_W-1:0] == dest_port)
            begin
                match.found = 1'b1;
                match.slot  = SLOT_W'(i);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        match.found |-> (int'(match.slot) < SLOT_COUNT))
        else $error("matched slot beyond slot count");

    assert property (@(posedge clk) disable iff (!rst_n)
        !match.found |-> match.slot == '0)
        else $error("slot index set without a match");

    assert property (@(posedge clk) disable iff (!rst_n)
        match.found |-> slot_reg[match.slot][PORT_W])
        else $error("match reported on an invalid slot");

endmodule

`default_nettype wire

// File: src/udprd_result_queue.sv
// Four-entry result queue; takes up to two beats per cycle, sends one unless stalled.
// Depends on udprd_pkg.
`default_nettype none

module udprd_result_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [1:0]         push_count,
    input  wire udprd_pkg::result_t push_first,
    input  wire udprd_pkg::result_t push_second,
    output logic                    room,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output udprd_pkg::result_t      head
);
    import udprd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    assign pop       = out_valid && !out_stall;
    assign out_valid = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];
    // keep room for the two beats a single item can produce
    assign room      = count_reg <= CNT_W'(QUEUE_DEPTH - 2);

    assign count_next = count_reg + CNT_W'(push_count) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_count);
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        push_count != 2'd0 |-> room)
        else $error("push without room");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push_count == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("queue count moved while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (PTR_W'(wr_ptr_reg - rd_ptr_reg) == PTR_W'(count_reg)))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: src/udp_receive_port_demux.sv
// UDP receive port demultiplexer: header parse, slot match, payload forward.
// Each result beat is written into the result queue and leaves from its head in order.
// Throughput: one byte per cycle while the queue has room; a final byte that is
//   also payload yields two beats, which the four-entry queue sends one at a time.
// Reset: asynchronous, clears slot registers, parse state and the queue.
// Depends on udprd_pkg, udprd_slot_match, udprd_result_queue.
`default_nettype none

module udp_receive_port_demux #(
    parameter int SLOT_COUNT = udprd_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [udprd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [udprd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         data_byte,
    input  wire logic                               end_of_packet,
    input  wire logic [31:0]                        source_address,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    result_kind,
    output logic [7:0]                              payload_byte,
    output logic [udprd_pkg::SLOT_W-1:0]            slot_index,
    output logic                                    delivered,
    output logic [31:0]                             peer_address,
    output logic [udprd_pkg::PORT_W-1:0]            peer_port,
    output logic [15:0]                             payload_length,
    output logic                                    final_result
);
    import udprd_pkg::*;

    logic [15:0]        pos_reg;
    logic [PORT_W-1:0]  src_port_reg;
    logic [PORT_W-1:0]  dst_port_reg;
    logic [15:0]        plen_reg;
    logic               match_found_reg;
    logic [SLOT_W-1:0]  matched_slot_reg;
    logic [31:0]        held_addr_reg;

    logic [PORT_W-1:0]  src_port_next;
    logic [PORT_W-1:0]  dst_port_next;
    logic [15:0]        plen_next;
    logic               match_found_next;
    logic [SLOT_W-1:0]  matched_slot_next;
    logic [31:0]        held_addr_next;

    match_t             match;
    logic               room;
    logic               accept;
    logic               is_payload;
    logic [15:0]        received;
    logic [15:0]        total;
    logic [15:0]        dlen;
    logic               deliver;
    result_t            pay_beat;
    result_t            desc_beat;
    result_t            head;
    logic [1:0]         push_count;

    udprd_slot_match #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dest_port (dst_port_next),
        .match     (match)
    );

    assign in_stall = !room;
    assign accept   = in_valid && room;

    // header field capture by byte position
    always_comb
    begin
        src_port_next     = src_port_reg;
        dst_port_next     = dst_port_reg;
        plen_next         = plen_reg;
        match_found_next  = match_found_reg;
        matched_slot_next = matched_slot_reg;
        held_addr_next    = (pos_reg == 16'd0) ? source_address : held_addr_reg;
        unique case (pos_reg)
            16'd0: src_port_next = {data_byte, 8'h00};
            16'd1: src_port_next = {src_port_reg[15:8], data_byte};
            16'd2: dst_port_next = {data_byte, 8'h00};
            16'd3:
            begin
                dst_port_next     = {dst_port_reg[15:8], data_byte};
                match_found_next  = match.found;
                matched_slot_next = match.slot;
            end
            16'd4: plen_next = {data_byte, 8'h00};
            16'd5: plen_next = {plen_reg[15:8], data_byte};
            default: ;
        endcase
    end

    always_comb
    begin
        is_payload = (pos_reg >= HEADER_BYTES) && (pos_reg != POS_MAX)
                     && (pos_reg < plen_next) && match_found_next;
        received   = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 16'd1;
        total      = (plen_next < received) ? plen_next : received;
        dlen       = (total >= HEADER_BYTES) ? total - HEADER_BYTES : 16'd0;
        deliver    = (received >= HEADER_BYTES) && match_found_next;

        pay_beat              = '0;
        pay_beat.result_kind  = KIND_PAYLOAD;
        pay_beat.payload_byte = data_byte;
        pay_beat.slot_index   = matched_slot_next;

        desc_beat                = '0;
        desc_beat.result_kind    = KIND_DESCRIPTOR;
        desc_beat.slot_index     = deliver ? matched_slot_next : '0;
        desc_beat.delivered      = deliver;
        desc_beat.peer_address   = held_addr_next;
        desc_beat.peer_port      = deliver ? src_port_next : '0;
        desc_beat.payload_length = deliver ? dlen : 16'd0;
        desc_beat.final_result   = 1'b1;

        push_count = accept ? 2'(is_payload) + 2'(end_of_packet) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            src_port_reg     <= '0;
            dst_port_reg     <= '0;
            plen_reg         <= '0;
            match_found_reg  <= 1'b0;
            matched_slot_reg <= '0;
            held_addr_reg    <= '0;
        end
        else if (accept)
        begin
            if (end_of_packet)
            begin
                // drop all per-datagram state
                pos_reg          <= '0;
                src_port_reg     <= '0;
                dst_port_reg     <= '0;
                plen_reg         <= '0;
                match_found_reg  <= 1'b0;
                matched_slot_reg <= '0;
                held_addr_reg    <= '0;
            end
            else
            begin
                if (pos_reg != POS_MAX)
                begin
                    pos_reg <= pos_reg + 16'd1;
                end
                src_port_reg     <= src_port_next;
                dst_port_reg     <= dst_port_next;
                plen_reg         <= plen_next;
                match_found_reg  <= match_found_next;
                matched_slot_reg <= matched_slot_next;
                held_addr_reg    <= held_addr_next;
            end
        end
    end

    udprd_result_queue u_result_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push_first  (is_payload ? pay_beat : desc_beat),
        .push_second (desc_beat),
        .room        (room),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .head        (head)
    );

    assign result_kind    = head.result_kind;
    assign payload_byte   = head.payload_byte;
    assign slot_index     = head.slot_index;
    assign delivered      = head.delivered;
    assign peer_address   = head.peer_address;
    assign peer_port      = head.peer_port;
    assign payload_length = head.payload_length;
    assign final_result   = head.final_result;

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_packet) |=> (pos_reg == 16'd0 && !match_found_reg))
        else $error("datagram state not cleared after final byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        is_payload |-> (pos_reg >= HEADER_BYTES && match_found_reg))
        else $error("payload forwarded before header or without a match");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !end_of_packet && pos_reg != POS_MAX) |=> pos_reg == $past(pos_reg) + 16'd1)
        else $error("byte position did not advance");

endmodule

`default_nettype wire
